// ===== sv/tmce_pkg.sv =====
// Package with shared types and constants for the tour mutation cost engine.
package tmce_pkg;

    localparam int MAX_CITIES = 256;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 8;
    localparam int POS_BITS   = 9;
    localparam int COST_BITS  = 42;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_LOAD    = 3'd0;
    localparam kind_t KIND_SWAP    = 3'd1;
    localparam kind_t KIND_BLOCK   = 3'd2;
    localparam kind_t KIND_REVERSE = 3'd3;
    localparam kind_t KIND_ROTATE  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_SWAP_RD,
        ST_SWAP_WAIT,
        ST_SWAP_WR1,
        ST_SWAP_WR2,
        ST_SWAP_NEXT,
        ST_COST_START,
        ST_COST_RD,
        ST_COST_WAIT,
        ST_COST_ACC,
        ST_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic                capture;   // latch the input beat
        logic                load_wr;   // write the loaded city
        logic                rd_pair;   // read positions lo and hi
        logic                wr_first;  // write hi data to lo
        logic                wr_second; // write lo data to hi
        logic                step_pair; // advance to the next pair
        logic                next_phase;// set up next reversal phase
        logic                cost_init; // start the cost walk
        logic                cost_rd;   // read edge endpoints
        logic                cost_acc;  // accumulate one edge
        logic                finish;    // publish result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_load;
        logic op_error;
        logic no_work;     // valid but nothing to move
        logic pair_done;   // pair walk finished in current phase
        logic last_phase;  // no further reversal phase
        logic cost_done;   // all edges summed
    } status_t;

endpackage

// ===== sv/tmce_ctrl.sv =====
// Controller state machine of the tour mutation cost engine.
module tmce_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_beat,
    input  logic              out_beat,
    input  tmce_pkg::status_t sts,
    output tmce_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              out_valid
);

    tmce_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmce_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            tmce_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (in_beat) begin
                    cmd.capture = 1'b1;
                    state_next  = tmce_pkg::ST_CHECK;
                end
            end
            tmce_pkg::ST_CHECK: begin
                if (sts.op_error || sts.no_work) begin
                    state_next = tmce_pkg::ST_COST_START;
                end else if (sts.is_load) begin
                    state_next = tmce_pkg::ST_LOAD;
                end else begin
                    state_next = tmce_pkg::ST_SWAP_RD;
                end
            end
            tmce_pkg::ST_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = tmce_pkg::ST_COST_START;
            end
            tmce_pkg::ST_SWAP_RD: begin
                if (sts.pair_done) begin
                    if (sts.last_phase) begin
                        state_next = tmce_pkg::ST_COST_START;
                    end else begin
                        cmd.next_phase = 1'b1;
                    end
                end else begin
                    cmd.rd_pair = 1'b1;
                    state_next  = tmce_pkg::ST_SWAP_WAIT;
                end
            end
            tmce_pkg::ST_SWAP_WAIT: state_next = tmce_pkg::ST_SWAP_WR1;
            tmce_pkg::ST_SWAP_WR1: begin
                cmd.wr_first = 1'b1;
                state_next   = tmce_pkg::ST_SWAP_WR2;
            end
            tmce_pkg::ST_SWAP_WR2: begin
                cmd.wr_second = 1'b1;
                state_next    = tmce_pkg::ST_SWAP_NEXT;
            end
            tmce_pkg::ST_SWAP_NEXT: begin
                cmd.step_pair = 1'b1;
                state_next    = tmce_pkg::ST_SWAP_RD;
            end
            tmce_pkg::ST_COST_START: begin
                cmd.cost_init = 1'b1;
                state_next    = tmce_pkg::ST_COST_RD;
            end
            tmce_pkg::ST_COST_RD: begin
                cmd.cost_rd = 1'b1;
                state_next  = tmce_pkg::ST_COST_WAIT;
            end
            tmce_pkg::ST_COST_WAIT: state_next = tmce_pkg::ST_COST_ACC;
            tmce_pkg::ST_COST_ACC: begin
                cmd.cost_acc = 1'b1;
                if (sts.cost_done) begin
                    cmd.finish = 1'b1;
                    state_next = tmce_pkg::ST_OUT;
                end else begin
                    state_next = tmce_pkg::ST_COST_RD;
                end
            end
            tmce_pkg::ST_OUT: begin
                out_valid = 1'b1;
                busy      = 1'b0;
                if (out_beat) begin
                    state_next = tmce_pkg::ST_IDLE;
                end
            end
            default: state_next = tmce_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== sv/tmce_datapath.sv =====
// Datapath of the tour mutation cost engine: coordinate memory, pointers, cost sum.
module tmce_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tmce_pkg::POS_BITS-1:0]     num_cities,
    input  logic [2:0]                        in_kind,
    input  logic [tmce_pkg::POS_BITS-1:0]     in_a,
    input  logic [tmce_pkg::POS_BITS-1:0]     in_b,
    input  logic [tmce_pkg::POS_BITS-1:0]     in_m,
    input  logic [tmce_pkg::POS_BITS-1:0]     in_n,
    input  logic [tmce_pkg::COORD_BITS-1:0]   in_x,
    input  logic [tmce_pkg::COORD_BITS-1:0]   in_y,
    input  tmce_pkg::cmd_t                    cmd,
    output tmce_pkg::status_t                 sts,
    output logic [tmce_pkg::COST_BITS-1:0]    cost,
    output logic                              op_err
);

    localparam int PB = tmce_pkg::POS_BITS;
    localparam int AB = tmce_pkg::ADDR_BITS;
    localparam int CB = tmce_pkg::COORD_BITS;
    localparam int WB = PB + 2; // room for sums of three positions

    logic [2*CB-1:0] mem_x [tmce_pkg::MAX_CITIES];
    logic [2*CB-1:0] mem_y_unused;

    logic [2:0]    kind_reg;
    logic [PB-1:0] a_reg, b_reg, m_reg, n_reg;
    logic [CB-1:0] x_reg, y_reg;
    logic [PB-1:0] cnt_reg;
    logic [WB-1:0] lo_reg, hi_reg;
    logic [1:0]    phase_reg;
    logic [WB-1:0] blk_left_reg;
    logic [AB-1:0] rd0_addr, rd1_addr;
    logic [2*CB-1:0] rd0_reg, rd1_reg;
    logic [PB-1:0] idx_reg;
    logic [tmce_pkg::COST_BITS-1:0] sum_reg, cost_reg;
    logic          err_reg;

    logic [PB-1:0] cnt_eff;
    logic [WB-1:0] aw, bw, mw, nw, cw;
    logic          err_c, nowork_c;

    assign mem_y_unused = '0;

    always_comb begin
        if (num_cities < PB'(4)) cnt_eff = PB'(4);
        else if (num_cities > PB'(tmce_pkg::MAX_CITIES)) cnt_eff = PB'(tmce_pkg::MAX_CITIES);
        else cnt_eff = num_cities;
    end

    assign aw = WB'(a_reg);
    assign bw = WB'(b_reg);
    assign mw = WB'(m_reg);
    assign nw = WB'(n_reg);
    assign cw = WB'(cnt_reg);

    always_comb begin
        err_c    = 1'b0;
        nowork_c = 1'b0;
        case (kind_reg)
            tmce_pkg::KIND_LOAD: err_c = !(aw >= WB'(1) && aw <= cw);
            tmce_pkg::KIND_SWAP: begin
                err_c    = !(aw >= WB'(2) && aw <= cw && bw >= WB'(2) && bw <= cw);
                nowork_c = (a_reg == b_reg);
            end
            tmce_pkg::KIND_BLOCK:
                err_c = !(mw >= WB'(1) && aw >= WB'(2) && aw + mw <= bw && bw + mw <= cw + WB'(1));
            tmce_pkg::KIND_REVERSE: begin
                err_c    = !(aw >= WB'(2) && aw <= cw && aw + mw <= cw + WB'(1));
                nowork_c = (mw < WB'(2));
            end
            tmce_pkg::KIND_ROTATE:
                err_c = !(mw >= WB'(1) && nw >= WB'(1) && aw >= WB'(2)
                          && aw + mw + nw <= cw + WB'(1));
            default: err_c = 1'b1;
        endcase
    end

    assign sts.is_load    = (kind_reg == tmce_pkg::KIND_LOAD);
    assign sts.op_error   = err_c;
    assign sts.no_work    = nowork_c;
    // Block swap walks lo/hi upward together; others close lo and hi in.
    assign sts.pair_done  = (kind_reg == tmce_pkg::KIND_BLOCK) ? (blk_left_reg == '0)
                          : (lo_reg >= hi_reg);
    assign sts.last_phase = (kind_reg != tmce_pkg::KIND_ROTATE) || (phase_reg == 2'd2);
    assign sts.cost_done  = (idx_reg == cnt_reg - PB'(1));

    // Memory addressing: port 0 reads lo / edge start, port 1 hi / edge end.
    always_comb begin
        if (cmd.cost_rd) begin
            rd0_addr = idx_reg[AB-1:0];
            rd1_addr = (idx_reg == cnt_reg - PB'(1)) ? AB'(0) : AB'(idx_reg + PB'(1));
        end else begin
            rd0_addr = AB'(lo_reg - WB'(1));
            rd1_addr = AB'(hi_reg - WB'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_pair || cmd.cost_rd) begin
            rd0_reg <= mem_x[rd0_addr];
            rd1_reg <= mem_x[rd1_addr];
        end
        if (cmd.load_wr) begin
            mem_x[AB'(a_reg - PB'(1))] <= {y_reg, x_reg};
        end else if (cmd.wr_first) begin
            mem_x[AB'(lo_reg - WB'(1))] <= rd1_reg | mem_y_unused;
        end else if (cmd.wr_second) begin
            mem_x[AB'(hi_reg - WB'(1))] <= rd0_reg;
        end
    end

    // Squared distance of the fetched edge.
    logic [CB-1:0] dx, dy;
    logic [2*CB-1:0] dx2, dy2;
    always_comb begin
        dx  = (rd0_reg[CB-1:0] > rd1_reg[CB-1:0]) ? rd0_reg[CB-1:0] - rd1_reg[CB-1:0]
                                                   : rd1_reg[CB-1:0] - rd0_reg[CB-1:0];
        dy  = (rd0_reg[2*CB-1:CB] > rd1_reg[2*CB-1:CB]) ? rd0_reg[2*CB-1:CB] - rd1_reg[2*CB-1:CB]
                                                         : rd1_reg[2*CB-1:CB] - rd0_reg[2*CB-1:CB];
        dx2 = dx * dx;
        dy2 = dy * dy;
    end

    logic [tmce_pkg::COST_BITS-1:0] sum_next;
    assign sum_next = sum_reg + tmce_pkg::COST_BITS'(dx2) + tmce_pkg::COST_BITS'(dy2);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            a_reg    <= in_a;
            b_reg    <= in_b;
            m_reg    <= in_m;
            n_reg    <= in_n;
            x_reg    <= in_x;
            y_reg    <= in_y;
            cnt_reg  <= cnt_eff;
            phase_reg <= 2'd0;
            if (in_kind == tmce_pkg::KIND_BLOCK) begin
                lo_reg       <= WB'(in_a);
                hi_reg       <= WB'(in_b);
                blk_left_reg <= WB'(in_m);
            end else if (in_kind == tmce_pkg::KIND_SWAP) begin
                lo_reg       <= (in_a < in_b) ? WB'(in_a) : WB'(in_b);
                hi_reg       <= (in_a < in_b) ? WB'(in_b) : WB'(in_a);
                blk_left_reg <= '0;
            end else begin
                lo_reg       <= WB'(in_a);
                hi_reg       <= WB'(in_a) + WB'(in_m) - WB'(1);
                blk_left_reg <= '0;
            end
        end
        if (cmd.step_pair) begin
            if (kind_reg == tmce_pkg::KIND_BLOCK) begin
                lo_reg       <= lo_reg + WB'(1);
                hi_reg       <= hi_reg + WB'(1);
                blk_left_reg <= blk_left_reg - WB'(1);
            end else if (kind_reg == tmce_pkg::KIND_SWAP) begin
                hi_reg <= lo_reg;
            end else begin
                lo_reg <= lo_reg + WB'(1);
                hi_reg <= hi_reg - WB'(1);
            end
        end
        if (cmd.next_phase) begin
            phase_reg <= phase_reg + 2'd1;
            if (phase_reg == 2'd0) begin
                lo_reg <= aw + mw;
                hi_reg <= aw + mw + nw - WB'(1);
            end else begin
                lo_reg <= aw;
                hi_reg <= aw + mw + nw - WB'(1);
            end
        end
        if (cmd.cost_init) begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.cost_acc) begin
            sum_reg <= sum_next;
            idx_reg <= idx_reg + PB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg <= '0;
            err_reg  <= 1'b0;
        end else if (cmd.finish) begin
            cost_reg <= sum_next;
            err_reg  <= err_c;
        end
    end

    assign cost   = cost_reg;
    assign op_err = err_reg;

endmodule

// ===== sv/tour_mutation_cost_engine_unit.sv =====
// Top level of the tour mutation cost engine: ports, register file, controller and datapath.
//
// The block keeps one travelling-salesman tour as packed x/y coordinates in a
// 256-entry memory. Each beat on the s_ channel either loads one city (kind 0)
// or applies one mutation: pair swap, block swap, segment reverse, or segment
// rotate. Position 1 never moves. Out-of-range operands set operand_error and
// leave the tour as it was. Every accepted beat yields exactly one m_ beat
// carrying the closed-tour sum of squared edge lengths after that item.
// Only one item is in flight: s_tready is high only while the engine is idle,
// so it stays low from the accepted beat until its result has been taken.
// Each exchange runs through read, read wait, two writes through the one write
// port and pointer step, and each edge of the cost walk through read, read
// wait and accumulate; a load does its single write and then the cost walk, and
// a rejected or empty item goes straight to the cost walk. The next beat is
// taken at the earliest once the result has been taken and the engine idles.
// Reset clears the controller and the reported cost; the tour memory holds
// garbage until loaded. A stalled m_ side simply holds the result. num_cities
// sits at APB address 0 and must be written only while idle.
module tour_mutation_cost_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields low to high: position_a[8:0], position_b[17:9], length_m[26:18],
    // length_n[35:27], city_x[51:36], city_y[67:52], zero pad.
    input  logic [71:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tour_cost[41:0], zero pad.
    output logic [47:0] m_tdata,
    // operand_error[0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_NUM_CITIES = 3'd0;

    logic [tmce_pkg::POS_BITS-1:0] num_cities_reg;
    tmce_pkg::cmd_t    cmd;
    tmce_pkg::status_t sts;
    logic busy, out_valid, in_beat, out_beat;
    logic [tmce_pkg::COST_BITS-1:0] cost;
    logic op_err;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NUM_CITIES) ? 32'(num_cities_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cities_reg <= 9'd32;
        end else if (psel && penable && pwrite && paddr == ADDR_NUM_CITIES) begin
            num_cities_reg <= pwdata[tmce_pkg::POS_BITS-1:0];
        end
    end

    // The input is taken only while the controller idles with no result pending.
    assign s_tready = !busy && !out_valid;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = out_valid;
    assign out_beat = m_tvalid && m_tready;
    assign m_tdata  = 48'(cost);
    assign m_tuser  = op_err;

    tmce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    tmce_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .num_cities (num_cities_reg),
        .in_kind    (s_tuser),
        .in_a       (s_tdata[8:0]),
        .in_b       (s_tdata[17:9]),
        .in_m       (s_tdata[26:18]),
        .in_n       (s_tdata[35:27]),
        .in_x       (s_tdata[51:36]),
        .in_y       (s_tdata[67:52]),
        .cmd        (cmd),
        .sts        (sts),
        .cost       (cost),
        .op_err     (op_err)
    );

`ifndef SYNTHESIS
    // No new item is taken while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");
    // A captured beat always leads to work, never straight to output.
    assert property (@(posedge aclk) disable iff (!aresetn) in_beat |=> !m_tvalid)
        else $error("result appeared without processing");
    // Memory writes never coincide with a cost read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.cost_rd && (cmd.wr_first || cmd.wr_second || cmd.load_wr)))
        else $error("write during cost walk");
`endif

endmodule

// ===== dv/tour_mutation_cost_engine_unit_tb.sv =====
// Self-checking testbench for the tour mutation cost engine: random and directed mutations.
`timescale 1ns / 100ps

module tour_mutation_cost_engine_unit_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // Fields low to high: position_a, position_b, length_m, length_n, city_x, city_y, pad.
    logic [71:0] s_tdata;
    // kind
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // tour_cost, pad.
    logic [47:0] m_tdata;
    // operand_error
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tour_mutation_cost_engine_unit DUT (.*);

    // Expected result of one beat; the cost is only defined once every
    // active position holds a loaded city.
    typedef struct {
        logic [41:0] cost;
        logic        err;
        bit          cost_known;
    } tour_result_t;

    // Shadow copy of the tour; index 0 holds position 1.
    logic [15:0]  shadow_x [tmce_pkg::MAX_CITIES];
    logic [15:0]  shadow_y [tmce_pkg::MAX_CITIES];
    bit           loaded   [tmce_pkg::MAX_CITIES];
    int           city_limit;
    tour_result_t pending_costs[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           long_hold;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Generous overall timeout for the run.
    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp_count(int value);
        if (value < 4) return 4;
        if (value > tmce_pkg::MAX_CITIES) return tmce_pkg::MAX_CITIES;
        return value;
    endfunction

    function automatic void exchange(int p, int q);
        logic [15:0] t;
        bit          f;
        t = shadow_x[p-1]; shadow_x[p-1] = shadow_x[q-1]; shadow_x[q-1] = t;
        t = shadow_y[p-1]; shadow_y[p-1] = shadow_y[q-1]; shadow_y[q-1] = t;
        f = loaded[p-1];   loaded[p-1]   = loaded[q-1];   loaded[q-1]   = f;
    endfunction

    function automatic void flip_span(int lo, int hi);
        while (lo < hi) begin
            exchange(lo, hi);
            lo++;
            hi--;
        end
    endfunction

    function automatic bit all_loaded();
        for (int i = 0; i < city_limit; i++) begin
            if (!loaded[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [41:0] closed_tour_cost();
        logic [63:0] sum;
        logic [63:0] dx;
        logic [63:0] dy;
        int          nxt;
        sum = 0;
        for (int i = 0; i < city_limit; i++) begin
            nxt = (i + 1 == city_limit) ? 0 : i + 1;
            dx = (shadow_x[i] > shadow_x[nxt]) ? shadow_x[i] - shadow_x[nxt]
                                               : shadow_x[nxt] - shadow_x[i];
            dy = (shadow_y[i] > shadow_y[nxt]) ? shadow_y[i] - shadow_y[nxt]
                                               : shadow_y[nxt] - shadow_y[i];
            sum += dx * dx + dy * dy;
        end
        if (sum > 64'h3FF_FFFF_FFFF) sum = 64'h3FF_FFFF_FFFF;
        return sum[41:0];
    endfunction

    // Applies one item to the shadow tour and returns the expected result.
    function automatic tour_result_t apply_mutation(tmce_pkg::kind_t kind, int a, int b,
                                                    int m, int n,
                                                    logic [15:0] cx, logic [15:0] cy);
        tour_result_t r;
        int cnt;
        cnt = city_limit;
        r.err = 1'b0;
        case (kind)
            tmce_pkg::KIND_LOAD: begin
                if (a >= 1 && a <= cnt) begin
                    shadow_x[a-1] = cx;
                    shadow_y[a-1] = cy;
                    loaded[a-1]   = 1'b1;
                end else r.err = 1'b1;
            end
            tmce_pkg::KIND_SWAP: begin
                if (a >= 2 && a <= cnt && b >= 2 && b <= cnt) exchange(a, b);
                else r.err = 1'b1;
            end
            tmce_pkg::KIND_BLOCK: begin
                if (m >= 1 && a >= 2 && a + m <= b && b + m - 1 <= cnt) begin
                    for (int i = 0; i < m; i++) exchange(a + i, b + i);
                end else r.err = 1'b1;
            end
            tmce_pkg::KIND_REVERSE: begin
                if (a >= 2 && a <= cnt && a + m <= cnt + 1) begin
                    if (m >= 2) flip_span(a, a + m - 1);
                end else r.err = 1'b1;
            end
            tmce_pkg::KIND_ROTATE: begin
                if (m >= 1 && n >= 1 && a >= 2 && a + m + n <= cnt + 1) begin
                    flip_span(a, a + m - 1);
                    flip_span(a + m, a + m + n - 1);
                    flip_span(a, a + m + n - 1);
                end else r.err = 1'b1;
            end
            default: r.err = 1'b1;
        endcase
        r.cost       = closed_tour_cost();
        r.cost_known = all_loaded();
        return r;
    endfunction

    // Sends one beat; the expectation is queued when the beat is accepted.
    // s_tvalid stays high after the accepting edge so that a following beat
    // can go out back to back; drain_results lowers it.
    task automatic send_item(tmce_pkg::kind_t kind, int a, int b, int m, int n,
                             logic [15:0] cx, logic [15:0] cy);
        logic [8:0] fa, fb, fm, fn;
        fa = a[8:0]; fb = b[8:0]; fm = m[8:0]; fn = n[8:0];
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, cy, cx, fn, fm, fb, fa};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_costs.insert(pending_costs.size(),
                             apply_mutation(kind, fa, fb, fm, fn, cx, cy));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Writes num_cities over APB while the block is idle.
    task automatic write_city_count(int value);
        drain_results();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'd0; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        city_limit = clamp_count(value & 9'h1FF);
    endtask

    // Loads every active position so later costs cover loaded cities only.
    task automatic load_all_cities();
        for (int p = 1; p <= city_limit; p++)
            send_item(tmce_pkg::KIND_LOAD, p, 0, 0, 0, 16'($urandom()), 16'($urandom()));
    endtask

    // Receiver ready: random stalls, or one long hold-off counted here.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
            end
        end
    end

    // Result checker.
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_costs.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    tour_result_t e;
                    e = pending_costs.pop_front();
                    if (e.cost_known && m_tdata[41:0] !== e.cost) begin
                        $error("tour_cost expected %0d got %0d", e.cost, m_tdata[41:0]);
                        fail_count++;
                    end
                    if (m_tuser !== e.err) begin
                        $error("operand_error expected %0b got %0b", e.err, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic random_item();
        tmce_pkg::kind_t kind;
        int a, b, m, n, sel;
        sel = $urandom_range(99, 0);
        kind = tmce_pkg::kind_t'($urandom_range(4, 0));
        if (sel < 5) kind = tmce_pkg::kind_t'($urandom_range(7, 5));
        if (sel < 80) begin
            // Mostly well-formed operands inside the active tour.
            a = $urandom_range(city_limit, 2);
            b = $urandom_range(city_limit, 2);
            m = $urandom_range(city_limit - a + 1, 0);
            n = $urandom_range(city_limit - a + 1 - m, 0);
            if (kind == tmce_pkg::KIND_BLOCK) begin
                m = $urandom_range((city_limit - 1) / 2, 1);
                a = $urandom_range(city_limit - 2 * m + 1, 2);
                b = $urandom_range(city_limit - m + 1, a + m);
            end
            if (kind == tmce_pkg::KIND_ROTATE && m + n >= 2 && m == 0) begin
                m = 1;
                n = n - 1;
            end
            if (kind == tmce_pkg::KIND_LOAD) a = $urandom_range(city_limit, 1);
        end else begin
            a = $urandom_range(511, 0); b = $urandom_range(511, 0);
            m = $urandom_range(511, 0); n = $urandom_range(511, 0);
        end
        // A load outside the tour is harmless; one inside is always fine.
        send_item(kind, a, b, m, n, 16'($urandom()), 16'($urandom()));
    endtask

    task automatic test_directed();
        write_city_count(4);
        load_all_cities();
        send_item(tmce_pkg::KIND_LOAD, 1, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        send_item(tmce_pkg::KIND_LOAD, 2, 0, 0, 0, 16'h0000, 16'h0000);
        send_item(tmce_pkg::KIND_LOAD, 0, 0, 0, 0, 16'h1234, 16'h5678);
        send_item(tmce_pkg::KIND_LOAD, 5, 0, 0, 0, 16'h1234, 16'h5678);
        send_item(tmce_pkg::KIND_SWAP, 2, 4, 0, 0, 0, 0);
        send_item(tmce_pkg::KIND_SWAP, 3, 3, 0, 0, 0, 0);
        send_item(tmce_pkg::KIND_SWAP, 1, 3, 0, 0, 0, 0);
        send_item(tmce_pkg::KIND_BLOCK, 2, 3, 1, 0, 0, 0);
        send_item(tmce_pkg::KIND_BLOCK, 2, 3, 0, 0, 0, 0);
        send_item(tmce_pkg::KIND_REVERSE, 2, 0, 3, 0, 0, 0);
        send_item(tmce_pkg::KIND_REVERSE, 3, 0, 0, 0, 0, 0);
        send_item(tmce_pkg::KIND_REVERSE, 3, 0, 1, 0, 0, 0);
        send_item(tmce_pkg::KIND_REVERSE, 3, 0, 3, 0, 0, 0);
        send_item(tmce_pkg::KIND_ROTATE, 2, 0, 1, 2, 0, 0);
        send_item(tmce_pkg::KIND_ROTATE, 2, 0, 2, 2, 0, 0);
        send_item(tmce_pkg::kind_t'(5), 2, 3, 1, 1, 0, 0);
        send_item(tmce_pkg::kind_t'(7), 511, 511, 511, 511, 16'hFFFF, 16'hFFFF);
        // A count of zero behaves as four.
        write_city_count(0);
        send_item(tmce_pkg::KIND_SWAP, 2, 4, 0, 0, 0, 0);
    endtask

    task automatic test_random_phase(int sender_pct, int receiver_pct, int count, int items);
        write_city_count(count);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        load_all_cities();
        repeat (items) random_item();
    endtask

    task automatic test_backpressure();
        write_city_count(8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_all_cities();
        long_hold = 1'b1;
        repeat (10) random_item();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1'b0;
        city_limit = 32;
        for (int i = 0; i < tmce_pkg::MAX_CITIES; i++) begin
            shadow_x[i] = '0;
            shadow_y[i] = '0;
            loaded[i]   = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(0, 0, 12, 150);
        test_random_phase(54, 0, 511, 40);
        test_random_phase(0, 54, 20, 150);
        test_random_phase(9, 9, 256, 40);
        test_random_phase(54, 54, 5, 150);
        test_backpressure();

        drain_results();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
